FILE: rtl/baro_pkg.sv
// baro_pkg: widths, stage payload types, register indexes and clamp limits
// for the barometer compensation pipeline. No dependencies.

package baro_pkg;

   localparam int D_W       = 24;
   localparam int DT_W      = 25;
   localparam int PROD_W    = 42;
   localparam int T2_W      = 17;
   localparam int TEMP_W    = 19;
   localparam int OFF_W     = 36;
   localparam int SQ_W      = 35;
   localparam int TC_W      = 20;
   localparam int CORR_W    = 42;
   localparam int FIN_W     = 40;
   localparam int OUT_T_W   = 18;
   localparam int OUT_P_W   = 32;
   localparam int COEF_W    = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] REG_SENSOR_TYPE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SENS_COEF        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_COEF      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SENS_TEMP_COEF   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_TEMP_COEF = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_REF_TEMP_COEF    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_SLOPE_COEF  = 3'd6;

   localparam logic signed [PROD_W-1:0] T0_OFF_MIN  = -42'sd17179344900;
   localparam logic signed [PROD_W-1:0] T0_OFF_MAX  =  42'sd25769410560;
   localparam logic signed [PROD_W-1:0] T0_SENS_MIN = -42'sd8589672450;
   localparam logic signed [PROD_W-1:0] T0_SENS_MAX =  42'sd12884705280;
   localparam logic signed [PROD_W-1:0] T1_OFF_MIN  = -42'sd8589672450;
   localparam logic signed [PROD_W-1:0] T1_OFF_MAX  =  42'sd12884705280;
   localparam logic signed [PROD_W-1:0] T1_SENS_MIN = -42'sd4294836225;
   localparam logic signed [PROD_W-1:0] T1_SENS_MAX =  42'sd6442352640;

   localparam logic signed [OUT_T_W-1:0] OUT_T_MIN = -18'sd131072;
   localparam logic signed [OUT_T_W-1:0] OUT_T_MAX =  18'sd131071;

   typedef struct packed {
      logic              sensor_type;
      logic [COEF_W-1:0] sens_coef;
      logic [COEF_W-1:0] offset_coef;
      logic [COEF_W-1:0] sens_temp_coef;
      logic [COEF_W-1:0] offset_temp_coef;
      logic [COEF_W-1:0] ref_temp_coef;
      logic [COEF_W-1:0] temp_slope_coef;
   } cfg_type;

   typedef struct packed {
      logic [D_W-1:0]           d1;
      logic signed [TEMP_W-1:0] temp;
      logic [T2_W-1:0]          t2;
      logic signed [OFF_W-1:0]  off;
      logic signed [OFF_W-1:0]  sens;
   } front_type;

   typedef struct packed {
      logic [D_W-1:0]            d1;
      logic signed [OUT_T_W-1:0] temp;
      logic signed [FIN_W-1:0]   off;
      logic signed [FIN_W-1:0]   sens;
   } corr_type;

endpackage

FILE: rtl/baro_front.sv
// baro_front: three-stage front end forming dT, dT squared, first-order temperature and
// clamped offset and sensitivity. Depends on baro_pkg.

module baro_front
   import baro_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [D_W-1:0] raw_pressure,
   input  logic [D_W-1:0] raw_temperature,
   output logic           out_valid,
   input  logic           out_ready,
   output front_type      out_item
);

   logic [2:0] vld_ff, vld_in;
   logic [3:0] adv;

   logic [D_W-1:0]            d1_a_ff, d1_b_ff;
   logic signed [DT_W-1:0]    dt_ff, dt_in;
   logic signed [PROD_W-1:0]  p6_ff, p4_ff, p3_ff, p6_in, p4_in, p3_in;
   logic signed [2*DT_W-1:0]  pdd;
   logic [T2_W-1:0]           t2_b_ff, t2_in;
   front_type                 out_ff, out_in;

   logic signed [PROD_W-1:0]  p6_sh, p4_sh, p3_sh, off_base, sens_base;
   logic signed [PROD_W-1:0]  off_sum, sens_sum, off_lo, off_hi, sens_lo, sens_hi;
   logic signed [PROD_W-1:0]  off_cl, sens_cl;

   always_comb begin
      adv[3] = out_ready;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = in_valid;
      end
      if (adv[1]) begin
         vld_in[1] = vld_ff[0];
      end
      if (adv[2]) begin
         vld_in[2] = vld_ff[1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_item  = out_ff;

   // stage 1: dT
   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp_coef, 8'b0});

   // stage 2: coefficient products and dT squared
   assign p6_in = $signed({1'b0, cfg.temp_slope_coef}) * dt_ff;
   assign p4_in = $signed({1'b0, cfg.offset_temp_coef}) * dt_ff;
   assign p3_in = $signed({1'b0, cfg.sens_temp_coef}) * dt_ff;
   assign pdd   = dt_ff * dt_ff;
   assign t2_in = pdd[31+T2_W-1:31];

   // stage 3: temperature, offset and sensitivity with clamps
   always_comb begin
      p6_sh = p6_ff >>> 23;
      if (cfg.sensor_type) begin
         p4_sh     = p4_ff >>> 7;
         p3_sh     = p3_ff >>> 8;
         off_base  = $signed({10'b0, cfg.offset_coef, 16'b0});
         sens_base = $signed({11'b0, cfg.sens_coef, 15'b0});
         off_lo    = T1_OFF_MIN;
         off_hi    = T1_OFF_MAX;
         sens_lo   = T1_SENS_MIN;
         sens_hi   = T1_SENS_MAX;
      end else begin
         p4_sh     = p4_ff >>> 6;
         p3_sh     = p3_ff >>> 7;
         off_base  = $signed({9'b0, cfg.offset_coef, 17'b0});
         sens_base = $signed({10'b0, cfg.sens_coef, 16'b0});
         off_lo    = T0_OFF_MIN;
         off_hi    = T0_OFF_MAX;
         sens_lo   = T0_SENS_MIN;
         sens_hi   = T0_SENS_MAX;
      end
      off_sum  = off_base + p4_sh;
      sens_sum = sens_base + p3_sh;
      off_cl   = off_sum;
      if (off_sum > off_hi) begin
         off_cl = off_hi;
      end else if (off_sum < off_lo) begin
         off_cl = off_lo;
      end
      sens_cl = sens_sum;
      if (sens_sum > sens_hi) begin
         sens_cl = sens_hi;
      end else if (sens_sum < sens_lo) begin
         sens_cl = sens_lo;
      end
      out_in.d1   = d1_b_ff;
      out_in.temp = $signed(p6_sh[TEMP_W-1:0]) + 19'sd2000;
      out_in.t2   = t2_b_ff;
      out_in.off  = off_cl[OFF_W-1:0];
      out_in.sens = sens_cl[OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1_a_ff <= raw_pressure;
         dt_ff   <= dt_in;
      end
      if (adv[1]) begin
         d1_b_ff <= d1_a_ff;
         p6_ff   <= p6_in;
         p4_ff   <= p4_in;
         p3_ff   <= p3_in;
         t2_b_ff <= t2_in;
      end
      if (adv[2]) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: rtl/baro_corr.sv
// baro_corr: three-stage second-order correction of temperature, offset and
// sensitivity for both sensor types. Depends on baro_pkg.

module baro_corr
   import baro_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      sensor_type,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_item,
   output logic      out_valid,
   input  logic      out_ready,
   output corr_type  out_item
);

   logic [2:0] vld_ff, vld_in;
   logic [3:0] adv;

   logic signed [TC_W-1:0]    ta, tb, tc, tcorr_in, tcorr_ff;
   logic signed [2*TC_W-1:0]  sq_lo, sq_hi;
   logic [SQ_W-1:0]           dlo_ff, dhi_ff, dlo_in, dhi_in;
   logic                      lo_ff, vlo_ff, hi_ff, lo_in, vlo_in, hi_in;
   logic [D_W-1:0]            d1_a_ff, d1_b_ff;
   logic signed [OFF_W-1:0]   off_a_ff, sens_a_ff, off_b_ff, sens_b_ff;

   logic signed [CORR_W-1:0]  dlo_w, dhi_w, off2_in, sens2_in, off2_ff, sens2_ff;
   logic signed [OUT_T_W-1:0] temp_in, temp_ff;

   logic signed [CORR_W-1:0]  off_full, sens_full;
   corr_type                  out_ff, out_in;

   always_comb begin
      adv[3] = out_ready;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = in_valid;
      end
      if (adv[1]) begin
         vld_in[1] = vld_ff[0];
      end
      if (adv[2]) begin
         vld_in[2] = vld_ff[1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_item  = out_ff;

   // stage 1: temperature distances, squares, T2 removal below 20 degrees only
   always_comb begin
      ta       = $signed({in_item.temp[TEMP_W-1], in_item.temp}) - 20'sd2000;
      tb       = $signed({in_item.temp[TEMP_W-1], in_item.temp}) + 20'sd1500;
      tc       = $signed({in_item.temp[TEMP_W-1], in_item.temp}) - 20'sd4500;
      lo_in    = in_item.temp < 19'sd2000;
      vlo_in   = in_item.temp < -19'sd1500;
      hi_in    = in_item.temp > 19'sd4500;
      sq_lo    = ta * ta;
      sq_hi    = hi_in ? tc * tc : tb * tb;
      dlo_in   = sq_lo[SQ_W-1:0];
      dhi_in   = sq_hi[SQ_W-1:0];
      tcorr_in = $signed({in_item.temp[TEMP_W-1], in_item.temp})
                 - $signed({3'b0, (lo_in ? in_item.t2 : {T2_W{1'b0}})});
   end

   // stage 2: OFF2 and SENS2, temperature saturation
   always_comb begin
      dlo_w    = $signed({7'b0, dlo_ff});
      dhi_w    = $signed({7'b0, dhi_ff});
      off2_in  = '0;
      sens2_in = '0;
      if (!sensor_type) begin
         if (lo_ff) begin
            off2_in  = (dlo_w * 42'sd61) >>> 4;
            sens2_in = dlo_w <<< 1;
            if (vlo_ff) begin
               off2_in  = off2_in + dhi_w * 42'sd15;
               sens2_in = sens2_in + (dhi_w <<< 3);
            end
         end
      end else begin
         if (lo_ff) begin
            off2_in  = dlo_w * 42'sd3;
            sens2_in = (dlo_w * 42'sd7) >>> 3;
            if (vlo_ff) begin
               sens2_in = sens2_in + (dhi_w <<< 1);
            end
         end else if (hi_ff) begin
            sens2_in = -(dhi_w >>> 3);
         end
      end
      temp_in = tcorr_ff[OUT_T_W-1:0];
      if (tcorr_ff > $signed({{(TC_W-OUT_T_W){1'b0}}, OUT_T_MAX})) begin
         temp_in = OUT_T_MAX;
      end else if (tcorr_ff < $signed({{(TC_W-OUT_T_W){1'b1}}, OUT_T_MIN})) begin
         temp_in = OUT_T_MIN;
      end
   end

   // stage 3: apply corrections
   always_comb begin
      off_full     = $signed({{(CORR_W-OFF_W){off_b_ff[OFF_W-1]}}, off_b_ff}) - off2_ff;
      sens_full    = $signed({{(CORR_W-OFF_W){sens_b_ff[OFF_W-1]}}, sens_b_ff}) - sens2_ff;
      out_in.d1    = d1_b_ff;
      out_in.temp  = temp_ff;
      out_in.off   = off_full[FIN_W-1:0];
      out_in.sens  = sens_full[FIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dlo_ff    <= dlo_in;
         dhi_ff    <= dhi_in;
         lo_ff     <= lo_in;
         vlo_ff    <= vlo_in;
         hi_ff     <= hi_in;
         tcorr_ff  <= tcorr_in;
         d1_a_ff   <= in_item.d1;
         off_a_ff  <= in_item.off;
         sens_a_ff <= in_item.sens;
      end
      if (adv[1]) begin
         off2_ff   <= off2_in;
         sens2_ff  <= sens2_in;
         temp_ff   <= temp_in;
         d1_b_ff   <= d1_a_ff;
         off_b_ff  <= off_a_ff;
         sens_b_ff <= sens_a_ff;
      end
      if (adv[2]) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: rtl/baro_press.sv
// baro_press: two-stage pressure back end; split D1*SENS product, offset
// subtraction and final scaling into the result register. Depends on baro_pkg.

module baro_press
   import baro_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  corr_type                  in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [OUT_T_W-1:0] temperature,
   output logic signed [OUT_P_W-1:0] pressure
);

   localparam int SH_W  = FIN_W - 21;
   localparam int MHI_W = D_W + 1 + SH_W;
   localparam int MLO_W = D_W + 21;
   localparam int Q_W   = 46;

   logic [1:0] vld_ff, vld_in;
   logic [2:0] adv;

   logic signed [SH_W-1:0]    sh;
   logic signed [MHI_W-1:0]   mhi_in, mhi_ff;
   logic [MLO_W-1:0]          mlo;
   logic [D_W-1:0]            mlo_in, mlo_ff;
   logic signed [FIN_W-1:0]   off_ff;
   logic signed [OUT_T_W-1:0] temp_a_ff, temp_b_ff;
   logic signed [Q_W-1:0]     q;
   logic signed [OUT_P_W-1:0] press_in, press_ff;

   always_comb begin
      adv[2] = out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = in_valid;
      end
      if (adv[1]) begin
         vld_in[1] = vld_ff[0];
      end
   end

   assign in_ready    = adv[0];
   assign out_valid   = vld_ff[1];
   assign temperature = temp_b_ff;
   assign pressure    = press_ff;

   // stage 1: D1*SENS/2^21 as D1*(SENS>>21) plus the carry of D1*(SENS mod 2^21)
   always_comb begin
      sh     = in_item.sens[FIN_W-1:21];
      mhi_in = $signed({1'b0, in_item.d1}) * sh;
      mlo    = in_item.d1 * in_item.sens[20:0];
      mlo_in = mlo[MLO_W-1:21];
   end

   // stage 2: subtract OFF and scale; the operand ranges keep the result inside 32 bits
   always_comb begin
      q = $signed({{(Q_W-MHI_W){mhi_ff[MHI_W-1]}}, mhi_ff})
          + $signed({{(Q_W-D_W){1'b0}}, mlo_ff})
          - $signed({{(Q_W-FIN_W){off_ff[FIN_W-1]}}, off_ff});
      press_in = $signed({q[Q_W-1], q[Q_W-1:15]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mhi_ff    <= mhi_in;
         mlo_ff    <= mlo_in;
         off_ff    <= in_item.off;
         temp_a_ff <= in_item.temp;
      end
      if (adv[1]) begin
         press_ff  <= press_in;
         temp_b_ff <= temp_a_ff;
      end
   end

endmodule

FILE: rtl/barometer_compensation_core.sv
// barometer_compensation_core: top level with calibration registers and stream ports;
// uses baro_pkg, baro_front, baro_corr and baro_press.
// Throughput: one item per cycle through the eight-stage pipeline; a stalled result
// holds every full stage behind it, while empty stages upstream keep filling.
// Reset (synchronous): clears all stage valids and sets every calibration register to zero.

module barometer_compensation_core
   import baro_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,   // temperature[17:0], pressure[49:18], zero
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]     csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   front_type fr_item;
   corr_type  co_item;
   logic      fr_valid, fr_ready, co_valid, co_ready;
   logic signed [OUT_T_W-1:0] temperature;
   logic signed [OUT_P_W-1:0] pressure;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_SENSOR_TYPE:      cfg_in.sensor_type      = csr_wdata[0];
            REG_SENS_COEF:        cfg_in.sens_coef        = csr_wdata;
            REG_OFFSET_COEF:      cfg_in.offset_coef      = csr_wdata;
            REG_SENS_TEMP_COEF:   cfg_in.sens_temp_coef   = csr_wdata;
            REG_OFFSET_TEMP_COEF: cfg_in.offset_temp_coef = csr_wdata;
            REG_REF_TEMP_COEF:    cfg_in.ref_temp_coef    = csr_wdata;
            REG_TEMP_SLOPE_COEF:  cfg_in.temp_slope_coef  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   baro_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_pressure    (req_tdata[23:0]),
      .raw_temperature (req_tdata[47:24]),
      .out_valid       (fr_valid),
      .out_ready       (fr_ready),
      .out_item        (fr_item)
   );

   baro_corr u_corr (
      .clock       (clock),
      .reset       (reset),
      .sensor_type (cfg_ff.sensor_type),
      .in_valid    (fr_valid),
      .in_ready    (fr_ready),
      .in_item     (fr_item),
      .out_valid   (co_valid),
      .out_ready   (co_ready),
      .out_item    (co_item)
   );

   baro_press u_press (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (co_valid),
      .in_ready    (co_ready),
      .in_item     (co_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .temperature (temperature),
      .pressure    (pressure)
   );

   assign rsp_tdata = {6'b0, pressure, temperature};

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while result side is ready");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      fr_valid && !fr_ready |=> fr_valid && $stable(fr_item))
      else $error("front stage item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !fr_valid && !co_valid)
      else $error("pipeline not empty after reset");

endmodule

FILE: dv/baro_compensation_checker.sv
`timescale 1ns / 100ps
// Scoreboard for barometer_compensation_core: mirrors the calibration registers,
// predicts one compensated reading per accepted item and compares it on rsp.
// Depends on baro_pkg for register indexes, the calibration struct and clamp limits.

module baro_compensation_checker
   import baro_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [55:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]     csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic signed [OUT_T_W-1:0] temperature;
      logic signed [OUT_P_W-1:0] pressure;
   } baro_reading_type;

   localparam longint DT_LO = -64'sd16776960;
   localparam longint DT_HI = 64'sd16777216;
   localparam longint P_LO  = -64'sd2147483648;
   localparam longint P_HI  = 64'sd2147483647;

   cfg_type          cal;
   baro_reading_type readings_q[$];

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic baro_reading_type compensate(input cfg_type c,
                                                   input logic [23:0] d1_raw,
                                                   input logic [23:0] d2_raw);
      longint c1, c2, c3, c4, c5, c6, d1, d2;
      longint dt, temp, off, sens, t2, off2, sens2, dlo, dhi, press;
      baro_reading_type r;
      c1 = longint'(c.sens_coef);
      c2 = longint'(c.offset_coef);
      c3 = longint'(c.sens_temp_coef);
      c4 = longint'(c.offset_temp_coef);
      c5 = longint'(c.ref_temp_coef);
      c6 = longint'(c.temp_slope_coef);
      d1 = longint'(d1_raw);
      d2 = longint'(d2_raw);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      dt = limit(d2 - c5 * 256, DT_LO, DT_HI);
      temp = 2000 + ((c6 * dt) >>> 23);
      if (!c.sensor_type) begin
         off = limit(c2 * 131072 + ((c4 * dt) >>> 6),
                     longint'(T0_OFF_MIN), longint'(T0_OFF_MAX));
         sens = limit(c1 * 65536 + ((c3 * dt) >>> 7),
                      longint'(T0_SENS_MIN), longint'(T0_SENS_MAX));
         if (temp < 2000) begin
            dlo = (temp - 2000) * (temp - 2000);
            t2 = (dt * dt) >>> 31;
            off2 = (61 * dlo) >>> 4;
            sens2 = 2 * dlo;
            if (temp < -1500) begin
               dhi = (temp + 1500) * (temp + 1500);
               off2 += 15 * dhi;
               sens2 += 8 * dhi;
            end
         end
      end else begin
         off = limit(c2 * 65536 + ((c4 * dt) >>> 7),
                     longint'(T1_OFF_MIN), longint'(T1_OFF_MAX));
         sens = limit(c1 * 32768 + ((c3 * dt) >>> 8),
                      longint'(T1_SENS_MIN), longint'(T1_SENS_MAX));
         if (temp < 2000) begin
            dlo = (temp - 2000) * (temp - 2000);
            t2 = (dt * dt) >>> 31;
            off2 = 3 * dlo;
            sens2 = (7 * dlo) >>> 3;
            if (temp < -1500) begin
               dhi = (temp + 1500) * (temp + 1500);
               sens2 += 2 * dhi;
            end
         end else if (temp > 4500) begin
            dhi = (temp - 4500) * (temp - 4500);
            sens2 = -(dhi >>> 3);
         end
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
      press = ((((d1 * sens) >>> 21) - off) >>> 15);
      temp = limit(temp, longint'(OUT_T_MIN), longint'(OUT_T_MAX));
      press = limit(press, P_LO, P_HI);
      r.temperature = temp[OUT_T_W-1:0];
      r.pressure = press[OUT_P_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      baro_reading_type seen, want;
      int bad;
      bad = 0;
      if (reset) begin
         cal = '0;
         readings_q.delete();
         mismatches <= 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SENSOR_TYPE:      cal.sensor_type = csr_wdata[0];
               REG_SENS_COEF:        cal.sens_coef = csr_wdata;
               REG_OFFSET_COEF:      cal.offset_coef = csr_wdata;
               REG_SENS_TEMP_COEF:   cal.sens_temp_coef = csr_wdata;
               REG_OFFSET_TEMP_COEF: cal.offset_temp_coef = csr_wdata;
               REG_REF_TEMP_COEF:    cal.ref_temp_coef = csr_wdata;
               REG_TEMP_SLOPE_COEF:  cal.temp_slope_coef = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.temperature = rsp_tdata[17:0];
            seen.pressure = rsp_tdata[49:18];
            if (readings_q.size() == 0) begin
               $error("unexpected result: temperature %0d pressure %0d",
                      seen.temperature, seen.pressure);
               bad++;
            end else begin
               want = readings_q.pop_front();
               if (seen.temperature !== want.temperature) begin
                  $error("temperature: expected %0d, actual %0d",
                         want.temperature, seen.temperature);
                  bad++;
               end
               if (seen.pressure !== want.pressure) begin
                  $error("pressure: expected %0d, actual %0d", want.pressure, seen.pressure);
                  bad++;
               end
            end
         end
         if (req_tvalid && req_tready)
            readings_q.push_back(compensate(cal, req_tdata[23:0], req_tdata[47:24]));
         mismatches <= mismatches + bad;
         outstanding <= readings_q.size();
      end
   end

endmodule

FILE: dv/tb_barometer_compensation_core.sv
`timescale 1ns / 100ps
// Top of the barometer_compensation_core bench: clock, reset, calibration writes,
// item stimulus with random throttling and the verdict. Checking sits in
// baro_compensation_checker; both depend on baro_pkg.

module tb_barometer_compensation_core;
   import baro_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 50;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;   // raw_pressure[23:0], raw_temperature[47:24]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [55:0]           rsp_tdata;   // temperature[17:0], pressure[49:18], zero
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [COEF_W-1:0]     csr_wdata;
   int                    mismatches;
   int                    outstanding;

   cfg_type     cal;
   bit          throttle = 1'b1;
   int unsigned quiet_cycles = 0;
   int          edge_temps[6] = '{1999, 2000, -1500, -1501, 4500, 4501};

   barometer_compensation_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   baro_compensation_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // pick a raw temperature conversion that lands on the given first-order temperature
   function automatic logic [23:0] raw_temp_for(input int target);
      longint span, slope, dt, raw;
      span = longint'(target - 2000) * 64'sd8388608;
      slope = longint'(cal.temp_slope_coef);
      raw = longint'(cal.ref_temp_coef);
      if (slope == 0)
         dt = 0;
      else if (span > 0)
         dt = (span + slope - 1) / slope;
      else
         dt = span / slope;
      raw = raw * 256 + dt;
      if (raw < 0) raw = 0;
      if (raw > 64'sd16777215) raw = 64'sd16777215;
      return raw[23:0];
   endfunction

   function automatic logic [23:0] random_raw_temp();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 24'($urandom_range(0, 24'hFFFFFF));
      if (roll < 60) return raw_temp_for(edge_temps[$urandom_range(0, 5)]);
      return raw_temp_for(int'($urandom_range(0, 13000)) - 4000);
   endfunction

   function automatic logic [23:0] random_raw_pressure();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 24'h000000;
      if (roll < 10) return 24'hFFFFFF;
      return 24'($urandom_range(0, 24'hFFFFFF));
   endfunction

   function automatic cfg_type random_cal(input bit plausible);
      cfg_type c;
      c.sensor_type = 1'($urandom_range(0, 1));
      if (plausible) begin
         c.sens_coef        = 16'($urandom_range(30000, 60000));
         c.offset_coef      = 16'($urandom_range(30000, 60000));
         c.sens_temp_coef   = 16'($urandom_range(15000, 40000));
         c.offset_temp_coef = 16'($urandom_range(15000, 40000));
         c.ref_temp_coef    = 16'($urandom_range(24000, 40000));
         c.temp_slope_coef  = 16'($urandom_range(20000, 36000));
      end else begin
         c.sens_coef        = 16'($urandom_range(0, 16'hFFFF));
         c.offset_coef      = 16'($urandom_range(0, 16'hFFFF));
         c.sens_temp_coef   = 16'($urandom_range(0, 16'hFFFF));
         c.offset_temp_coef = 16'($urandom_range(0, 16'hFFFF));
         c.ref_temp_coef    = 16'($urandom_range(0, 16'hFFFF));
         c.temp_slope_coef  = 16'($urandom_range(0, 16'hFFFF));
      end
      return c;
   endfunction

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic load_calibration(input cfg_type c);
      cal = c;
      write_csr(REG_SENSOR_TYPE, {15'($urandom_range(0, 16'h7FFF)), c.sensor_type});
      write_csr(REG_SENS_COEF, c.sens_coef);
      write_csr(REG_OFFSET_COEF, c.offset_coef);
      write_csr(REG_SENS_TEMP_COEF, c.sens_temp_coef);
      write_csr(REG_OFFSET_TEMP_COEF, c.offset_temp_coef);
      write_csr(REG_REF_TEMP_COEF, c.ref_temp_coef);
      write_csr(REG_TEMP_SLOPE_COEF, c.temp_slope_coef);
      write_csr(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input logic [23:0] raw_p, input logic [23:0] raw_t);
      int unsigned gap;
      gap = throttle ? pick_gap() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {raw_t, raw_p};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
         end else begin
            rsp_tready <= !throttle || ($urandom_range(0, 9) < 7);
            hold = throttle ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type c;
      int phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      cal = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset calibration
      send_item(24'hFFFFFF, 24'hFFFFFF);
      send_item(24'h000000, 24'h000000);
      drain();

      // typical coefficients, first formulas
      c = '{1'b0, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
      load_calibration(c);
      send_item(24'h000000, 24'h000000);
      send_item(24'hFFFFFF, 24'hFFFFFF);
      send_item(24'h000000, 24'hFFFFFF);
      send_item(24'hFFFFFF, 24'h000000);
      send_item(24'd6465444, raw_temp_for(2000));
      send_item(24'd6465444, raw_temp_for(1999));
      send_item(24'd6465444, raw_temp_for(-1501));
      drain();

      // typical coefficients, second formulas
      c.sensor_type = 1'b1;
      load_calibration(c);
      send_item(24'd6465444, raw_temp_for(4500));
      send_item(24'd6465444, raw_temp_for(4501));
      send_item(24'd6465444, raw_temp_for(-1500));
      send_item(24'd6465444, raw_temp_for(-1501));
      send_item(24'd6465444, raw_temp_for(1999));
      send_item(24'hFFFFFF, 24'h000000);
      drain();

      // full-scale coefficients drive the temperature to both saturation limits
      load_calibration('{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_item(24'hFFFFFF, 24'h000000);
      send_item(24'h000000, 24'hFFFFFF);
      drain();
      load_calibration('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
      send_item(24'hFFFFFF, 24'hFFFFFF);
      send_item(24'h000000, 24'h000000);
      send_item(24'hFFFFFF, 24'h000000);
      drain();
      load_calibration('{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_item(24'hFFFFFF, 24'hFFFFFF);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         throttle = (phase % 3) != 1;
         load_calibration(random_cal((phase % 2) == 0));
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 39) == 0)
               drain();
            send_item(random_raw_pressure(), random_raw_temp());
         end
         drain();
      end

      repeat (12) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/baro_pkg.sv
rtl/baro_front.sv
rtl/baro_corr.sv
rtl/baro_press.sv
rtl/barometer_compensation_core.sv
dv/baro_compensation_checker.sv
dv/tb_barometer_compensation_core.sv
